// ----- src/mmpg_pkg.sv -----
// shared types and constants of the multi-motor pwm generator
package mmpg_pkg;

    localparam int CAL_REGS  = 4;
    localparam int CAL_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int PROD_W    = 14;
    localparam int MASK_W    = 4;

    localparam logic [1:0] OP_TICK      = 2'd0;
    localparam logic [1:0] OP_SET_SPEED = 2'd1;
    localparam logic [1:0] OP_STOP_ALL  = 2'd2;

    localparam logic [CAL_W-1:0] CAL_RESET  = 7'd127;
    localparam logic [CAL_W-1:0] CAL_SCALE  = 7'd127;
    localparam logic [7:0]       LEVEL_FULL = 8'd255;
    localparam logic [7:0]       LEVEL_BASE = 8'd65;
    localparam logic [7:0]       LEVEL_OFF  = 8'd0;
    localparam logic signed [7:0] SPEED_MIN     = -8'sd128;
    localparam logic signed [7:0] SPEED_MIN_CLP = -8'sd127;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [1:0]        channel;
        logic signed [7:0] speed;
    } cmd_t;

    typedef struct packed {
        logic [MASK_W-1:0] enable_mask;
        logic [MASK_W-1:0] forward_mask;
        logic [MASK_W-1:0] backward_mask;
        logic              pwm_running;
    } res_t;

    // registered command after clamping and scaling
    typedef struct packed {
        logic [1:0]        opcode;
        logic [1:0]        channel;
        logic signed [7:0] speed;
        logic [PROD_W-1:0] product;
    } stage_t;

endpackage

// ----- src/mmpg_stream_if.sv -----
// valid/ready stream channel carrying one word
interface mmpg_stream_if #(parameter type word_t = logic);
    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- src/mmpg_scale.sv -----
// input stage: calibration registers, speed clamp and speed times calibration product
module mmpg_scale (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mmpg_pkg::cmd_t                      cmd_word,
    input  logic                                load,
    input  logic                                adv,
    input  logic                                cfg_we,
    input  logic [mmpg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mmpg_pkg::CAL_W-1:0]          cfg_data,
    output logic                                stage_valid,
    output mmpg_pkg::stage_t                    stage_word
);

    logic [mmpg_pkg::CAL_W-1:0] cal_reg [mmpg_pkg::CAL_REGS];
    logic                       valid_reg;
    logic                       valid_next;
    mmpg_pkg::stage_t           word_reg;
    mmpg_pkg::stage_t           word_next;
    logic signed [7:0]          spd_clamped;
    logic [6:0]                 spd_mag;
    logic [7:0]                 spd_neg;

    always_comb
    begin
        spd_clamped = (cmd_word.speed == mmpg_pkg::SPEED_MIN) ?
                      mmpg_pkg::SPEED_MIN_CLP : cmd_word.speed;
        spd_neg     = 8'(-spd_clamped);
        spd_mag     = spd_clamped[7] ? spd_neg[6:0] : spd_clamped[6:0];

        word_next.opcode  = cmd_word.opcode;
        word_next.channel = cmd_word.channel;
        word_next.speed   = spd_clamped;
        word_next.product = mmpg_pkg::PROD_W'(spd_mag) *
                            mmpg_pkg::PROD_W'(cal_reg[cmd_word.channel]);

        if (load)
            valid_next = 1'b1;
        else if (adv)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            for (int i = 0; i < mmpg_pkg::CAL_REGS; i++)
                cal_reg[i] <= mmpg_pkg::CAL_RESET;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cfg_we)
                cal_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            word_reg <= word_next;
    end

    assign stage_valid = valid_reg;
    assign stage_word  = word_reg;

endmodule

// ----- src/mmpg_core.sv -----
// channel state: duty levels, drive masks, pwm counter and their update per word
module mmpg_core #(
    parameter int NUM_CHANNELS = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  mmpg_pkg::stage_t stage_word,
    output mmpg_pkg::res_t   result
);

    localparam int EXT_W = (NUM_CHANNELS > mmpg_pkg::MASK_W) ? NUM_CHANNELS : mmpg_pkg::MASK_W;

    logic [7:0]              cnt_reg, cnt_next;
    logic                    running_reg, running_next;
    logic signed [7:0]       speed_reg [NUM_CHANNELS];
    logic signed [7:0]       speed_next [NUM_CHANNELS];
    logic [7:0]              level_reg [NUM_CHANNELS];
    logic [7:0]              level_next [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] en_reg, en_next;
    logic [NUM_CHANNELS-1:0] fwd_reg, fwd_next;
    logic [NUM_CHANNELS-1:0] bwd_reg, bwd_next;

    logic [20:0]             prod_x129;
    logic [6:0]              quo_est;
    logic [14:0]             rem_est;
    logic [6:0]              quo;
    logic [8:0]              quo_x3;
    logic [7:0]              lvl_new;
    logic [NUM_CHANNELS-1:0] chg;
    logic                    any_on;
    logic [EXT_W-1:0]        en_ext, fwd_ext, bwd_ext;

    // divide by 127: estimate with 129/2^14, then one correction step
    always_comb
    begin
        prod_x129 = (21'(stage_word.product) << 7) + 21'(stage_word.product);
        quo_est   = prod_x129[20:14];
        rem_est   = 15'(stage_word.product) + 15'(quo_est) - (15'(quo_est) << 7);
        quo       = (rem_est >= 15'(mmpg_pkg::CAL_SCALE)) ? 7'(quo_est + 7'd1) : quo_est;
        quo_x3    = 9'(quo) + (9'(quo) << 1);
        lvl_new   = 8'(quo_x3 >> 1) + mmpg_pkg::LEVEL_BASE;
    end

    always_comb
    begin
        cnt_next     = cnt_reg;
        running_next = running_reg;
        en_next      = en_reg;
        fwd_next     = fwd_reg;
        bwd_next     = bwd_reg;
        any_on       = 1'b0;
        chg          = '0;
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            speed_next[i] = speed_reg[i];
            level_next[i] = level_reg[i];
        end

        case (stage_word.opcode)
            mmpg_pkg::OP_TICK:
            begin
                if (running_reg)
                begin
                    cnt_next = cnt_reg - 8'd1;
                    for (int i = 0; i < NUM_CHANNELS; i++)
                    begin
                        if (cnt_next == 8'd0)
                        begin
                            if (level_reg[i] != mmpg_pkg::LEVEL_FULL)
                                en_next[i] = 1'b0;
                        end
                        else if (level_reg[i] == cnt_next)
                            en_next[i] = 1'b1;
                    end
                end
            end
            mmpg_pkg::OP_SET_SPEED:
            begin
                for (int i = 0; i < NUM_CHANNELS; i++)
                    chg[i] = (int'(stage_word.channel) == i) &&
                             (speed_reg[i] != stage_word.speed);
                for (int i = 0; i < NUM_CHANNELS; i++)
                begin
                    if (chg[i])
                    begin
                        speed_next[i] = stage_word.speed;
                        if (stage_word.speed == 8'sd0)
                        begin
                            level_next[i] = mmpg_pkg::LEVEL_OFF;
                            en_next[i]    = 1'b0;
                            fwd_next[i]   = 1'b0;
                            bwd_next[i]   = 1'b0;
                        end
                        else
                        begin
                            level_next[i] = lvl_new;
                            en_next[i]    = 1'b1;
                            fwd_next[i]   = !stage_word.speed[7];
                            bwd_next[i]   = stage_word.speed[7];
                        end
                    end
                end
                for (int i = 0; i < NUM_CHANNELS; i++)
                    if (level_next[i] != mmpg_pkg::LEVEL_OFF)
                        any_on = 1'b1;
                if (|chg)
                begin
                    if (stage_word.speed == 8'sd0)
                    begin
                        if (!any_on)
                            running_next = 1'b0;
                    end
                    else if (lvl_new != mmpg_pkg::LEVEL_FULL && !running_reg)
                    begin
                        // start from a cleared counter and run the zero event now
                        cnt_next     = 8'd0;
                        running_next = 1'b1;
                        for (int i = 0; i < NUM_CHANNELS; i++)
                            if (level_next[i] != mmpg_pkg::LEVEL_FULL)
                                en_next[i] = 1'b0;
                    end
                end
            end
            mmpg_pkg::OP_STOP_ALL:
            begin
                running_next = 1'b0;
                en_next      = '0;
                fwd_next     = '0;
                bwd_next     = '0;
                for (int i = 0; i < NUM_CHANNELS; i++)
                begin
                    speed_next[i] = 8'sd0;
                    level_next[i] = mmpg_pkg::LEVEL_OFF;
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= 8'd0;
            running_reg <= 1'b0;
            en_reg      <= '0;
            fwd_reg     <= '0;
            bwd_reg     <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                speed_reg[i] <= 8'sd0;
                level_reg[i] <= mmpg_pkg::LEVEL_OFF;
            end
        end
        else if (adv)
        begin
            cnt_reg     <= cnt_next;
            running_reg <= running_next;
            en_reg      <= en_next;
            fwd_reg     <= fwd_next;
            bwd_reg     <= bwd_next;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                speed_reg[i] <= speed_next[i];
                level_reg[i] <= level_next[i];
            end
        end
    end

    always_comb
    begin
        en_ext               = EXT_W'(en_reg);
        fwd_ext              = EXT_W'(fwd_reg);
        bwd_ext              = EXT_W'(bwd_reg);
        result.enable_mask   = en_ext[mmpg_pkg::MASK_W-1:0];
        result.forward_mask  = fwd_ext[mmpg_pkg::MASK_W-1:0];
        result.backward_mask = bwd_ext[mmpg_pkg::MASK_W-1:0];
        result.pwm_running   = running_reg;
    end

endmodule

// ----- src/multi_motor_pwm_generator_top.sv -----
// top level of the multi-motor pwm generator
// Four-channel motor pwm driven by command words on the cmd channel (tick, set speed,
// stop all) with one status word per command on the res channel: the enable, forward
// and backward masks and the running flag as they stand after that command. The block
// takes one command word per clock cycle while res.ready holds; the first stage
// registers the command together with the clamped speed times calibration product
// (the one multiplier), the second divides by 127, forms the duty level and updates
// the channel state, whose registers are also the result word. Rate is set by that
// state update, which every command needs before the next one. The input stage keeps
// accepting while a status word waits for res.ready, and stalls only once both stages
// are full. The user must write the calibration registers through cfg_we, cfg_index and
// cfg_data only while the block is idle; the block does not enforce it. They reset to 127.
module multi_motor_pwm_generator_top #(
    parameter int NUM_CHANNELS = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    mmpg_stream_if.sink                       cmd,
    mmpg_stream_if.source                     res,
    input  logic                              cfg_we,
    input  logic [mmpg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mmpg_pkg::CAL_W-1:0]        cfg_data
);

    // pipeline handshake
    logic             stage_valid;
    logic             load;
    logic             adv;
    logic             out_valid_reg;
    logic             out_valid_next;
    mmpg_pkg::stage_t stage_word;
    mmpg_pkg::res_t   result;

    // a staged word moves on when the result slot is free or being emptied
    assign adv       = stage_valid && (!out_valid_reg || res.ready);
    assign cmd.ready = !stage_valid || adv;
    assign load      = cmd.valid && cmd.ready;

    mmpg_scale u_scale (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_word    (cmd.data),
        .load        (load),
        .adv         (adv),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .stage_valid (stage_valid),
        .stage_word  (stage_word)
    );

    // state registers double as the result register
    mmpg_core #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .stage_word (stage_word),
        .result     (result)
    );

    always_comb
    begin
        if (adv)
            out_valid_next = 1'b1;
        else if (res.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign res.valid = out_valid_reg;
    assign res.data  = result;

    // a channel never drives both directions
    a_dir_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        (result.forward_mask & result.backward_mask) == '0)
        else $error("forward and backward both set on a channel");

    // an enabled channel always has a direction
    a_enable_has_dir: assert property (@(posedge clk) disable iff (!rst_n)
        (result.enable_mask & ~(result.forward_mask | result.backward_mask)) == '0)
        else $error("channel enabled without direction");

    // a staged word with a free result slot lands in the result register next cycle
    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid && !out_valid_reg) |=> out_valid_reg)
        else $error("staged word did not reach result register");

    // a word is taken at the input only if the stage is free or moving on
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready && stage_valid) |-> adv)
        else $error("input stage overwritten");

endmodule

// ----- test/tb.sv -----
// self-checking testbench of the multi-motor pwm generator with its own status predictor
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // opcode value that the block must leave without effect
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int NCH           = 4;
    localparam int HOLD_AT       = 100;   // status word count that starts the long hold-off
    localparam int HOLD_CYCLES   = 150;   // length of that hold-off in clock cycles
    localparam int STALL_LIMIT   = 2000;  // cycles with no word moving before giving up
    localparam int SETTLE_CYCLES = 6;     // two-stage pipe, plus margin
    localparam int MAX_REPORTS   = 10;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_we;
    logic [mmpg_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [mmpg_pkg::CAL_W-1:0]     cfg_data;

    mmpg_stream_if #(.word_t(mmpg_pkg::cmd_t)) cmd_ch ();
    mmpg_stream_if #(.word_t(mmpg_pkg::res_t)) res_ch ();

    multi_motor_pwm_generator_top #(
        .NUM_CHANNELS(NCH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd_ch),
        .res      (res_ch),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // shadow copy of the motor state, advanced once per accepted command
    // ------------------------------------------------------------------
    logic [mmpg_pkg::CAL_W-1:0]  cal_reg [NCH];
    logic [7:0]                  pwm_count;
    logic                        pwm_on;
    logic signed [7:0]           chan_speed [NCH];
    logic [7:0]                  chan_level [NCH];
    logic [mmpg_pkg::MASK_W-1:0] en_bits;
    logic [mmpg_pkg::MASK_W-1:0] fw_bits;
    logic [mmpg_pkg::MASK_W-1:0] bw_bits;

    mmpg_pkg::cmd_t cmd_backlog [$];      // command words not yet offered to the block
    mmpg_pkg::res_t expected_status [$];  // status words predicted but not yet seen

    int send_idle_pct;
    int recv_stall_pct;
    int status_errors;
    int status_seen;
    int hold_left;
    int quiet_cycles;

    // counter wrapped to zero: every channel below full level drops its enable
    function automatic void apply_zero_crossing();
        for (int i = 0; i < NCH; i++)
        begin
            if (chan_level[i] != mmpg_pkg::LEVEL_FULL)
                en_bits[i] = 1'b0;
        end
    endfunction

    // |trunc(speed * cal / 127)| * 3 / 2 + 65, kept to 8 bits
    function automatic logic [7:0] duty_level_of(logic signed [7:0] sp,
                                                 logic [mmpg_pkg::CAL_W-1:0] cal);
        int scaled;
        scaled = int'(sp) * int'(cal) / int'(mmpg_pkg::CAL_SCALE);
        if (scaled < 0)
            scaled = -scaled;
        return 8'(scaled * 3 / 2 + int'(mmpg_pkg::LEVEL_BASE));
    endfunction

    function automatic mmpg_pkg::res_t step_motor_model(mmpg_pkg::cmd_t c);
        logic signed [7:0] sp;
        logic              any_on;
        int                ch;
        case (c.opcode)
            mmpg_pkg::OP_TICK:
            begin
                // a tick is ignored while the pwm is stopped
                if (pwm_on)
                begin
                    pwm_count = pwm_count - 8'd1;
                    if (pwm_count == 8'd0)
                        apply_zero_crossing();
                    else
                    begin
                        for (int i = 0; i < NCH; i++)
                        begin
                            if (chan_level[i] == pwm_count)
                                en_bits[i] = 1'b1;
                        end
                    end
                end
            end
            mmpg_pkg::OP_SET_SPEED:
            begin
                ch = int'(c.channel);
                sp = (c.speed == mmpg_pkg::SPEED_MIN) ? mmpg_pkg::SPEED_MIN_CLP : c.speed;
                // an unchanged speed leaves everything as it is
                if (sp != chan_speed[ch])
                begin
                    chan_speed[ch] = sp;
                    if (sp == 8'sd0)
                    begin
                        // channel stop, and pwm stop once no level is left
                        chan_level[ch] = mmpg_pkg::LEVEL_OFF;
                        en_bits[ch]    = 1'b0;
                        fw_bits[ch]    = 1'b0;
                        bw_bits[ch]    = 1'b0;
                        any_on         = 1'b0;
                        for (int i = 0; i < NCH; i++)
                        begin
                            if (chan_level[i] != mmpg_pkg::LEVEL_OFF)
                                any_on = 1'b1;
                        end
                        if (!any_on)
                            pwm_on = 1'b0;
                    end
                    else
                    begin
                        chan_level[ch] = duty_level_of(sp, cal_reg[ch]);
                        bw_bits[ch]    = sp[7];
                        fw_bits[ch]    = !sp[7];
                        en_bits[ch]    = 1'b1;
                        // full level alone never starts the counter
                        if (chan_level[ch] != mmpg_pkg::LEVEL_FULL && !pwm_on)
                        begin
                            pwm_count = 8'd0;
                            apply_zero_crossing();
                            pwm_on = 1'b1;
                        end
                    end
                end
            end
            mmpg_pkg::OP_STOP_ALL:
            begin
                // counter keeps its value, everything else clears
                for (int i = 0; i < NCH; i++)
                begin
                    chan_speed[i] = 8'sd0;
                    chan_level[i] = mmpg_pkg::LEVEL_OFF;
                end
                en_bits = '0;
                fw_bits = '0;
                bw_bits = '0;
                pwm_on  = 1'b0;
            end
            default: ;
        endcase
        return '{enable_mask: en_bits, forward_mask: fw_bits,
                 backward_mask: bw_bits, pwm_running: pwm_on};
    endfunction

    // ------------------------------------------------------------------
    // command driver: offers backlog words, predicts on each acceptance
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_ch.valid && cmd_ch.ready)
                expected_status.push_back(step_motor_model(cmd_ch.data));
            // slot is free when nothing is offered or the offer was just taken
            if (!cmd_ch.valid || cmd_ch.ready)
            begin
                if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cmd_ch.data  <= cmd_backlog.pop_front();
                    cmd_ch.valid <= 1'b1;
                end
                else
                    cmd_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // status monitor: checks each word against the oldest prediction,
    // owns res ready including the long hold-off
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        mmpg_pkg::res_t want;
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                status_seen++;
                if (status_seen == HOLD_AT)
                    hold_left = HOLD_CYCLES;
                if (expected_status.size() == 0)
                begin
                    status_errors++;
                    if (status_errors <= MAX_REPORTS)
                        $display("status word en=%h fw=%h bw=%h run=%b with nothing expected",
                                 res_ch.data.enable_mask, res_ch.data.forward_mask,
                                 res_ch.data.backward_mask, res_ch.data.pwm_running);
                end
                else
                begin
                    want = expected_status.pop_front();
                    if (res_ch.data.enable_mask !== want.enable_mask
                        || res_ch.data.forward_mask !== want.forward_mask
                        || res_ch.data.backward_mask !== want.backward_mask
                        || res_ch.data.pwm_running !== want.pwm_running)
                    begin
                        status_errors++;
                        if (status_errors <= MAX_REPORTS)
                        begin
                            $display("status word %0d: expected en=%h fw=%h bw=%h run=%b",
                                     status_seen, want.enable_mask, want.forward_mask,
                                     want.backward_mask, want.pwm_running);
                            $display("    got en=%h fw=%h bw=%h run=%b",
                                     res_ch.data.enable_mask, res_ch.data.forward_mask,
                                     res_ch.data.backward_mask, res_ch.data.pwm_running);
                        end
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog on cycles in which no word moves on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic void queue_cmd(logic [1:0] op, logic [1:0] ch, logic signed [7:0] sp);
        cmd_backlog.push_back('{opcode: op, channel: ch, speed: sp});
    endfunction

    // speed biased toward stop, the clamp corner and the smallest magnitudes
    function automatic logic signed [7:0] pick_speed();
        int r;
        r = $urandom_range(99);
        if (r < 15)
            return 8'sd0;
        if (r < 35)
        begin
            case ($urandom_range(4))
                0:       return 8'sd127;
                1:       return -8'sd128;
                2:       return -8'sd127;
                3:       return 8'sd1;
                default: return -8'sd1;
            endcase
        end
        return 8'($urandom_range(255));
    endfunction

    // mostly short runs, some long enough to wrap the 8-bit counter
    function automatic void queue_ticks();
        int len;
        len = ($urandom_range(99) < 15) ? $urandom_range(150, 300) : $urandom_range(1, 30);
        repeat (len)
            queue_cmd(mmpg_pkg::OP_TICK, 2'($urandom_range(3)), 8'($urandom_range(255)));
    endfunction

    // random part: speed changes followed by tick runs, with noise and broken sequences
    function automatic void queue_random_cmds(int count);
        int start;
        int r;
        start = cmd_backlog.size();
        while (cmd_backlog.size() - start < count)
        begin
            r = $urandom_range(99);
            if (r < 60)
            begin
                repeat ($urandom_range(1, 3))
                    queue_cmd(mmpg_pkg::OP_SET_SPEED, 2'($urandom_range(3)), pick_speed());
                queue_ticks();
            end
            else if (r < 75)
                queue_ticks();
            else if (r < 85)
            begin
                // any opcode including the unused one, any fields
                repeat ($urandom_range(1, 4))
                    queue_cmd(2'($urandom_range(3)), 2'($urandom_range(3)),
                              8'($urandom_range(255)));
            end
            else if (r < 92)
            begin
                queue_cmd(mmpg_pkg::OP_SET_SPEED, 2'($urandom_range(3)), 8'sd0);
                queue_ticks();
            end
            else
            begin
                queue_cmd(mmpg_pkg::OP_STOP_ALL, 2'($urandom_range(3)),
                          8'($urandom_range(255)));
                if ($urandom_range(1))
                    queue_ticks();
            end
        end
        // cut the tail of the last run so the phase has exactly count words
        while (cmd_backlog.size() - start > count)
            void'(cmd_backlog.pop_back());
    endfunction

    // sender pause: wait until every offered word has its status word back
    task automatic wait_for_quiet();
        do
            @(negedge clk);
        while (cmd_backlog.size() != 0 || cmd_ch.valid || expected_status.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // write all four calibration registers while the block is idle
    task automatic program_calibration(logic [mmpg_pkg::CAL_W-1:0] c0,
                                       logic [mmpg_pkg::CAL_W-1:0] c1,
                                       logic [mmpg_pkg::CAL_W-1:0] c2,
                                       logic [mmpg_pkg::CAL_W-1:0] c3);
        logic [mmpg_pkg::CAL_W-1:0] vals [NCH];
        vals = '{c0, c1, c2, c3};
        for (int i = 0; i < NCH; i++)
        begin
            @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= mmpg_pkg::CFG_IDX_W'(i);
            cfg_data  <= vals[i];
            cal_reg[i] = vals[i];
        end
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        cmd_ch.valid   = 1'b0;
        cmd_ch.data    = '0;
        res_ch.ready   = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        status_errors  = 0;
        status_seen    = 0;
        hold_left      = 0;
        quiet_cycles   = 0;
        pwm_count      = 8'd0;
        pwm_on         = 1'b0;
        en_bits        = '0;
        fw_bits        = '0;
        bw_bits        = '0;
        for (int i = 0; i < NCH; i++)
        begin
            cal_reg[i]    = mmpg_pkg::CAL_RESET;
            chan_speed[i] = 8'sd0;
            chan_level[i] = mmpg_pkg::LEVEL_OFF;
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part, calibration still at reset values
        queue_cmd(mmpg_pkg::OP_TICK, 2'd0, 8'sd0);              // tick while stopped
        queue_cmd(mmpg_pkg::OP_SET_SPEED, 2'd0, 8'sd127);       // full level, pwm stays off
        queue_cmd(mmpg_pkg::OP_SET_SPEED, 2'd0, 8'sd127);       // same speed again
        queue_cmd(mmpg_pkg::OP_TICK, 2'd3, -8'sd1);
        queue_cmd(mmpg_pkg::OP_SET_SPEED, 2'd1, -8'sd128);      // clamped to -127, backward
        queue_cmd(mmpg_pkg::OP_SET_SPEED, 2'd1, -8'sd127);      // equals the clamped speed
        queue_cmd(mmpg_pkg::OP_SET_SPEED, 2'd2, 8'sd1);         // lowest level, starts the pwm
        queue_cmd(mmpg_pkg::OP_TICK, 2'd0, 8'sd0);              // counter wraps to 255
        queue_cmd(mmpg_pkg::OP_SET_SPEED, 2'd3, -8'sd1);        // while running, no restart
        queue_cmd(mmpg_pkg::OP_TICK, 2'd0, 8'sd0);
        queue_cmd(OP_UNUSED, 2'd3, -8'sd1);
        queue_cmd(mmpg_pkg::OP_SET_SPEED, 2'd2, 8'sd0);         // one channel stops
        queue_cmd(mmpg_pkg::OP_SET_SPEED, 2'd0, 8'sd0);
        queue_cmd(mmpg_pkg::OP_SET_SPEED, 2'd1, 8'sd0);
        queue_cmd(mmpg_pkg::OP_SET_SPEED, 2'd3, 8'sd0);         // last level gone, pwm stops
        queue_cmd(mmpg_pkg::OP_TICK, 2'd1, 8'sd5);
        queue_cmd(mmpg_pkg::OP_SET_SPEED, 2'd2, -8'sd2);        // restart, counter cleared
        queue_cmd(mmpg_pkg::OP_SET_SPEED, 2'd1, 8'sd100);
        queue_cmd(mmpg_pkg::OP_TICK, 2'd0, 8'sd0);
        queue_cmd(mmpg_pkg::OP_TICK, 2'd0, 8'sd0);
        queue_cmd(mmpg_pkg::OP_STOP_ALL, 2'd3, 8'sd127);
        queue_cmd(mmpg_pkg::OP_TICK, 2'd2, -8'sd128);           // tick after stop all
        queue_cmd(mmpg_pkg::OP_SET_SPEED, 2'd0, 8'sd0);         // zero onto a stopped channel
        queue_cmd(mmpg_pkg::OP_SET_SPEED, 2'd3, 8'sh55);
        queue_cmd(mmpg_pkg::OP_SET_SPEED, 2'd2, -8'sd86);
        wait_for_quiet();

        // no idling; the long receiver hold-off falls in here
        program_calibration(7'd127, 7'd0, 7'd64, 7'd1);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        queue_random_cmds(170);
        wait_for_quiet();
        queue_random_cmds(170);
        wait_for_quiet();

        // sender mostly idle
        program_calibration(7'd0, 7'd127, 7'd1, 7'd100);
        send_idle_pct  = 83;
        recv_stall_pct = 0;
        queue_random_cmds(330);
        wait_for_quiet();

        // receiver mostly stalling, random calibration
        program_calibration(7'($urandom_range(127)), 7'($urandom_range(127)),
                            7'($urandom_range(127)), 7'($urandom_range(127)));
        send_idle_pct  = 0;
        recv_stall_pct = 83;
        queue_random_cmds(330);
        wait_for_quiet();

        // both sides idle now and then
        program_calibration(7'd0, 7'd0, 7'd127, 7'd127);
        send_idle_pct  = 24;
        recv_stall_pct = 24;
        queue_random_cmds(330);
        wait_for_quiet();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (status_errors == 0 && expected_status.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
